// File: design/smma_pkg.sv
package smma_pkg;

  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;
  localparam int DIM_W  = 4;

  typedef enum logic [1:0] {
    KIND_WR_A = 2'd0,
    KIND_WR_B = 2'd1,
    KIND_MUL  = 2'd2,
    KIND_ADD  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ADD_ERR = 2'd1,
    ST_MUL_ERR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FEED,
    S_WAIT,
    S_EMIT_RD,
    S_EMIT_WR,
    S_ERR
  } state_t;

  // one beat travelling along the cell chain
  typedef struct packed {
    logic              v;
    logic              clr;
    logic [IDX_W-1:0]  k;
    logic [DATA_W-1:0] a;
  } chain_t;

endpackage

// File: design/smma_cell.sv
module smma_cell #(
  parameter int DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smma_pkg::chain_t              chain_in,
  output smma_pkg::chain_t              chain_out,
  input  logic                          wr_en,
  input  logic [smma_pkg::IDX_W-1:0]    wr_addr,
  input  logic [smma_pkg::DATA_W-1:0]   wr_data,
  output logic [smma_pkg::DATA_W-1:0]   acc
);
  import smma_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // one column of B
  logic [DATA_W-1:0] col_mem [DEPTH];

  chain_t            s1_r;
  logic [DATA_W-1:0] b_r;
  logic [DATA_W-1:0] p_r;
  logic              v2_r, clr2_r;
  logic [DATA_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      col_mem[wr_addr[AW-1:0]] <= wr_data;
    end
    b_r <= col_mem[chain_in.k[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r   <= '0;
      v2_r   <= 1'b0;
      clr2_r <= 1'b0;
    end else begin
      s1_r   <= chain_in;
      v2_r   <= s1_r.v;
      clr2_r <= s1_r.clr;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= DATA_W'(s1_r.a * b_r);
    if (v2_r) begin
      acc_r <= clr2_r ? p_r : acc_r + p_r;
    end
  end

  assign chain_out = s1_r;
  assign acc       = acc_r;

endmodule

// File: design/small_matrix_multiply_add.sv
// Loads are accepted while idle and may follow back to back.
// Multiply: per row of A, its elements are fed into the cell chain, a drain wait lets
// the last beat pass every cell, then results go out as the output slot frees.
// Add: per row, row i of B is fed once, then drain and results. Errors: a last beat.
// Synchronous active-low reset: dimensions return to 8, controller idle; the
// element stores are not cleared.
module small_matrix_multiply_add #(
  parameter int MAX_DIM = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // row_index[2:0], col_index[5:3], element[37:6], zeros
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // out_row[2:0], out_col[5:3], out_value[37:6], zeros
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_wdata
);
  import smma_pkg::*;

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int WAIT_N = MAX_DIM + 4;
  localparam int WW = $clog2(WAIT_N + 1);

  logic [DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_W'(8);
      a_cols_r <= DIM_W'(8);
      b_rows_r <= DIM_W'(8);
      b_cols_r <= DIM_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_ROWS: a_rows_r <= cfg_wdata;
        REG_A_COLS: a_cols_r <= cfg_wdata;
        REG_B_ROWS: b_rows_r <= cfg_wdata;
        REG_B_COLS: b_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  function automatic logic [DW-1:0] dim_eff(input logic [DIM_W-1:0] v);
    logic [DW-1:0] r;
    if (v == '0) r = DW'(1);
    else if (int'(v) > MAX_DIM) r = DW'(MAX_DIM);
    else r = DW'(v);
    return r;
  endfunction

  logic [DW-1:0] ar_e, ac_e, br_e, bc_e;
  assign ar_e = dim_eff(a_rows_r);
  assign ac_e = dim_eff(a_cols_r);
  assign br_e = dim_eff(b_rows_r);
  assign bc_e = dim_eff(b_cols_r);

  logic [IDX_W-1:0]  in_row, in_col;
  logic [DATA_W-1:0] in_elem;
  kind_t             in_kind;
  logic              in_acc, in_range;
  assign in_row   = in_tdata[2:0];
  assign in_col   = in_tdata[5:3];
  assign in_elem  = in_tdata[37:6];
  assign in_kind  = kind_t'(in_tuser);
  assign in_acc   = in_tvalid && in_tready;
  assign in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);

  state_t        state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt, k_r, k_nxt;
  logic [WW-1:0] w_r, w_nxt;
  logic          is_add_r, is_add_nxt;
  status_t       err_r, err_nxt;

  logic          out_tvalid_r;
  logic          slot_free;
  logic [DW-1:0] n_feed, n_col;
  logic          k_last_feed, k_last_col, i_last;

  assign slot_free   = !out_tvalid_r || out_tready;
  assign n_feed      = is_add_r ? DW'(1) : ac_e;
  assign n_col       = is_add_r ? ac_e : bc_e;
  assign k_last_feed = (DW'(k_r) + DW'(1)) == n_feed;
  assign k_last_col  = (DW'(k_r) + DW'(1)) == n_col;
  assign i_last      = (DW'(i_r) + DW'(1)) == ar_e;

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    w_nxt      = w_r;
    is_add_nxt = is_add_r;
    err_nxt    = err_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_kind == KIND_MUL || in_kind == KIND_ADD)) begin
          is_add_nxt = (in_kind == KIND_ADD);
          i_nxt      = '0;
          k_nxt      = '0;
          if (in_kind == KIND_MUL && br_e != ac_e) begin
            err_nxt   = ST_MUL_ERR;
            state_nxt = S_ERR;
          end else if (in_kind == KIND_ADD && (ar_e != br_e || ac_e != bc_e)) begin
            err_nxt   = ST_ADD_ERR;
            state_nxt = S_ERR;
          end else begin
            state_nxt = S_FEED;
          end
        end
      end
      S_FEED: begin
        if (k_last_feed) begin
          k_nxt     = '0;
          w_nxt     = '0;
          state_nxt = S_WAIT;
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      S_WAIT: begin
        // let the last beat ripple through every cell
        if (w_r == WW'(WAIT_N)) state_nxt = S_EMIT_RD;
        else w_nxt = w_r + WW'(1);
      end
      S_EMIT_RD: state_nxt = S_EMIT_WR;
      S_EMIT_WR: begin
        if (slot_free) begin
          if (k_last_col) begin
            k_nxt = '0;
            if (i_last) begin
              state_nxt = S_IDLE;
            end else begin
              i_nxt     = i_r + IW'(1);
              state_nxt = S_FEED;
            end
          end else begin
            k_nxt     = k_r + IW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      S_ERR: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      i_r      <= '0;
      k_r      <= '0;
      w_r      <= '0;
      is_add_r <= 1'b0;
      err_r    <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      i_r      <= i_nxt;
      k_r      <= k_nxt;
      w_r      <= w_nxt;
      is_add_r <= is_add_nxt;
      err_r    <= err_nxt;
    end
  end

  // A store and control outputs
  logic [DATA_W-1:0] a_mem [MAX_DIM * MAX_DIM];
  logic [DATA_W-1:0] a_rd_r;
  logic [AW-1:0]     a_ra, a_wa;
  logic [DATA_W-1:0] a_wd;
  logic              a_we, b_we, feed_issue, emit_el, emit_err;
  logic [DATA_W-1:0] acc_w [MAX_DIM];
  logic [DATA_W-1:0] acc_sel, res_val;

  assign acc_sel = acc_w[k_r];

  always_comb begin
    in_tready  = (state_r == S_IDLE);
    feed_issue = (state_r == S_FEED);
    emit_el    = (state_r == S_EMIT_WR) && slot_free;
    emit_err   = (state_r == S_ERR) && slot_free;
    a_ra       = AW'(int'(i_r) * MAX_DIM + int'(k_r));
    res_val    = is_add_r ? acc_sel + a_rd_r : acc_sel;
    b_we       = (state_r == S_IDLE) && in_acc && in_kind == KIND_WR_B && in_range;
    if ((state_r == S_IDLE) && in_acc && in_kind == KIND_WR_A && in_range) begin
      a_we = 1'b1;
      a_wa = AW'(int'(in_row) * MAX_DIM + int'(in_col));
      a_wd = in_elem;
    end else begin
      a_we = emit_el && is_add_r;
      a_wa = a_ra;
      a_wd = res_val;
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[a_wa] <= a_wd;
    end
    a_rd_r <= a_mem[a_ra];
  end

  // chain feed: add loads row i of B into the cells via a multiply by one
  logic             fv_r, fclr_r, fone_r;
  logic [IW-1:0]    fk_r;
  chain_t           link [MAX_DIM + 1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= feed_issue;
    end
    fk_r   <= is_add_r ? i_r : k_r;
    fclr_r <= is_add_r || (k_r == '0);
    fone_r <= is_add_r;
  end

  always_comb begin
    link[0].v   = fv_r;
    link[0].clr = fclr_r;
    link[0].k   = IDX_W'(fk_r);
    link[0].a   = fone_r ? DATA_W'(1) : a_rd_r;
  end

  genvar g;
  generate
    for (g = 0; g < MAX_DIM; g++) begin : g_cell
      smma_cell #(.DEPTH(MAX_DIM)) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .chain_in  (link[g]),
        .chain_out (link[g+1]),
        .wr_en     (b_we && int'(in_col) == g),
        .wr_addr   (in_row),
        .wr_data   (in_elem),
        .acc       (acc_w[g])
      );
    end
  endgenerate

  // output register
  logic [IDX_W-1:0]  o_row_r, o_col_r;
  logic [DATA_W-1:0] o_val_r;
  logic              o_last_r;
  status_t           o_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit_el || emit_err) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (emit_el) begin
      o_row_r  <= IDX_W'(i_r);
      o_col_r  <= IDX_W'(k_r);
      o_val_r  <= res_val;
      o_last_r <= k_last_col && i_last;
      o_st_r   <= ST_OK;
    end else if (emit_err) begin
      o_row_r  <= '0;
      o_col_r  <= '0;
      o_val_r  <= '0;
      o_last_r <= 1'b1;
      o_st_r   <= err_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, o_val_r, o_col_r, o_row_r};
  assign out_tuser  = o_st_r;
  assign out_tlast  = o_last_r;

`ifndef SYNTH
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tlast)
    else $error("error result without last");
  a_feed_src: assert property (@(posedge clk) disable iff (!rst_n)
    fv_r |-> $past(state_r) == S_FEED)
    else $error("chain fed outside feed phase");
  a_a_write: assert property (@(posedge clk) disable iff (!rst_n)
    a_we |-> state_r == S_IDLE || (state_r == S_EMIT_WR && is_add_r))
    else $error("A written during multiply");
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FEED |-> DW'(k_r) < n_feed)
    else $error("feed counter out of range");
`endif

endmodule
